/* hw/rtl/fdis_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdis_pkg
// Shared types and constants for the filament dynamic-instability step.
// ----------------------------------------------------------------------------
package fdis_pkg;

  typedef enum logic [1:0] {
    ST_SHRINK = 2'd0,
    ST_GROW   = 2'd1,
    ST_PAUSE  = 2'd2
  } state_e;

  typedef enum logic [0:0] {
    CMD_STEP = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  localparam int unsigned RodIdxW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] REG_SHRINK_EXIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GROW_EXIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_EXIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GROW_STEP   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHRINK_STEP = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH  = 3'd6;

  localparam logic [15:0] OneQ12 = 16'd4096;
  localparam logic [32:0] OneQ24 = 33'd16777216;

  // Scaled exit probabilities of one state, Q8.24, plus roll * sum
  typedef struct packed {
    logic [31:0] p1;
    logic [32:0] sum;
    logic [48:0] rs;
  } exit_calc_t;

  // One table entry
  typedef struct packed {
    state_e      st;
    logic [31:0] len;
  } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/fdis_exit_pick.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdis_exit_pick
// Chooses the next state of one source state from the roll and the two
// scaled exit probabilities.
// ----------------------------------------------------------------------------
module fdis_exit_pick
  import fdis_pkg::*;
(
  input  exit_calc_t  calc_i,
  input  logic [15:0] roll_i,
  input  state_e      first_i,
  input  state_e      second_i,
  input  state_e      stay_i,
  output state_e      next_o
);

  logic [23:0] roll_q24;

  assign roll_q24 = {roll_i, 8'h00};

  always_comb begin
    priority if (calc_i.sum > OneQ24) begin
      // exits oversubscribed: split the roll in proportion
      next_o = (calc_i.rs < {1'b0, calc_i.p1, 16'h0000}) ? first_i : second_i;
    end else if ({8'h00, roll_q24} < calc_i.p1) begin
      next_o = first_i;
    end else if ({9'h000, roll_q24} < calc_i.sum) begin
      next_o = second_i;
    end else begin
      next_o = stay_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/filament_dynamic_instability_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// filament_dynamic_instability_step
// Filament table with load and stochastic step commands.
// ----------------------------------------------------------------------------
// Pipeline: an input beat passes the stage A, B, C, D and output registers.
// Throughput: one beat per cycle unless out_ready_i stalls; the table has one
// read and one write per cycle; a step on an entry being written is bypassed.
// Reset: handshake control is cleared and configuration registers take their
// reset values (max length all ones, the rest zero); the filament table is
// not cleared and an entry is undefined until loaded.
// ----------------------------------------------------------------------------
module filament_dynamic_instability_step
  import fdis_pkg::*;
#(
  parameter int unsigned NUM_FILAMENTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [RodIdxW-1:0]   rod_index_i,
  input  logic [15:0]          roll_i,
  input  logic                 stabilized_i,
  input  logic [15:0]          factor_rescue_i,
  input  logic [15:0]          factor_catastrophe_i,
  input  logic [15:0]          factor_grow_speed_i,
  input  logic [15:0]          factor_shrink_speed_i,
  input  logic [31:0]          load_length_i,
  input  logic [1:0]           load_state_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RodIdxW-1:0]   out_index_o,
  output logic [1:0]           new_state_o,
  output logic [31:0]          new_length_o,
  output logic                 state_changed_o
);

  localparam int unsigned IdxW = (NUM_FILAMENTS > 1) ? $clog2(NUM_FILAMENTS) : 1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [31:0] shrink_probs_q, grow_probs_q, pause_probs_q;
  logic [23:0] grow_step_q, shrink_step_q;
  logic [31:0] max_len_q, min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shrink_probs_q <= '0;
      grow_probs_q   <= '0;
      pause_probs_q  <= '0;
      grow_step_q    <= '0;
      shrink_step_q  <= '0;
      max_len_q      <= '1;
      min_len_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SHRINK_EXIT: shrink_probs_q <= cfg_wdata_i;
        REG_GROW_EXIT:   grow_probs_q   <= cfg_wdata_i;
        REG_PAUSE_EXIT:  pause_probs_q  <= cfg_wdata_i;
        REG_GROW_STEP:   grow_step_q    <= cfg_wdata_i[23:0];
        REG_SHRINK_STEP: shrink_step_q  <= cfg_wdata_i[23:0];
        REG_MAX_LENGTH:  max_len_q      <= cfg_wdata_i;
        REG_MIN_LENGTH:  min_len_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: A inputs, B products, C roll products,
  // D table read and update, O output register
  // --------------------------------------------------------------------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, o_vld_q;
  logic ld_o, mv_d, ld_d, mv_c, ld_c, mv_b, ld_b, mv_a, ld_a, in_acc;

  assign ld_o   = !o_vld_q || out_ready_i;
  assign mv_d   = d_vld_q && ld_o;
  assign ld_d   = !d_vld_q || mv_d;
  assign mv_c   = c_vld_q && ld_d;
  assign ld_c   = !c_vld_q || mv_c;
  assign mv_b   = b_vld_q && ld_c;
  assign ld_b   = !b_vld_q || mv_b;
  assign mv_a   = a_vld_q && ld_b;
  assign ld_a   = !a_vld_q || mv_a;
  assign in_acc = in_valid_i && ld_a;

  assign in_ready_o = ld_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (ld_a) a_vld_q <= in_acc;
      if (ld_b) b_vld_q <= mv_a;
      if (ld_c) c_vld_q <= mv_b;
      if (ld_d) d_vld_q <= mv_c;
      if (ld_o) o_vld_q <= mv_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register, index folded into the table range
  // --------------------------------------------------------------------------
  logic [RodIdxW-1:0] idx_fold;
  logic [26:0]        fold_sub;
  state_e             ld_st_sat;

  always_comb begin
    idx_fold = rod_index_i;
    fold_sub = '0;
    for (int k = RodIdxW - 1; k >= 0; k--) begin
      fold_sub = 27'(NUM_FILAMENTS) << k;
      if ((fold_sub < (27'd1 << RodIdxW)) && ({17'h0, idx_fold} >= fold_sub)) begin
        idx_fold = idx_fold - fold_sub[RodIdxW-1:0];
      end
    end
  end

  assign ld_st_sat = (load_state_i > ST_PAUSE) ? ST_PAUSE : state_e'(load_state_i);

  cmd_e               a_cmd_q;
  logic [RodIdxW-1:0] a_idx_q;
  logic [15:0]        a_roll_q, a_fr_q, a_fc_q, a_fvg_q, a_fvs_q;
  logic               a_stab_q;
  logic [31:0]        a_ld_len_q;
  state_e             a_ld_st_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cmd_q    <= cmd_e'(command_i);
      a_idx_q    <= idx_fold;
      a_roll_q   <= roll_i;
      a_stab_q   <= stabilized_i;
      a_fr_q     <= factor_rescue_i;
      a_fc_q     <= factor_catastrophe_i;
      a_fvg_q    <= factor_grow_speed_i;
      a_fvs_q    <= factor_shrink_speed_i;
      a_ld_len_q <= load_length_i;
      a_ld_st_q  <= ld_st_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: probability and speed products for every source state
  // --------------------------------------------------------------------------
  logic [15:0] pr, pc;
  logic [39:0] grow_prod, shrink_prod;

  assign pr          = a_stab_q ? a_fr_q : OneQ12;
  assign pc          = a_stab_q ? a_fc_q : OneQ12;
  assign grow_prod   = 40'(grow_step_q) * 40'(a_fvg_q);
  assign shrink_prod = 40'(shrink_step_q) * 40'(a_fvs_q);

  cmd_e               b_cmd_q;
  logic [RodIdxW-1:0] b_idx_q;
  logic [15:0]        b_roll_q;
  logic [31:0]        b_ld_len_q;
  state_e             b_ld_st_q;
  logic [31:0]        b_sg_q, b_sp_q, b_gs_q, b_gp_q, b_pg_q, b_ps_q;
  logic [27:0]        b_dg_q, b_ds_q;

  always_ff @(posedge clk_i) begin
    if (mv_a) begin
      b_cmd_q    <= a_cmd_q;
      b_idx_q    <= a_idx_q;
      b_roll_q   <= a_roll_q;
      b_ld_len_q <= a_ld_len_q;
      b_ld_st_q  <= a_ld_st_q;
      b_sg_q     <= 32'(shrink_probs_q[31:16]) * 32'(pr);
      b_sp_q     <= 32'(shrink_probs_q[15:0])  * 32'(pr);
      b_gs_q     <= 32'(grow_probs_q[31:16])   * 32'(pc);
      b_gp_q     <= 32'(grow_probs_q[15:0])    * 32'(pc);
      b_pg_q     <= 32'(pause_probs_q[31:16])  * 32'(pr);
      b_ps_q     <= 32'(pause_probs_q[15:0])   * 32'(pc);
      b_dg_q     <= a_stab_q ? grow_prod[39:12]   : {4'h0, grow_step_q};
      b_ds_q     <= a_stab_q ? shrink_prod[39:12] : {4'h0, shrink_step_q};
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: exit sums and roll * sum
  // --------------------------------------------------------------------------
  logic [32:0] sum_s, sum_g, sum_p;

  assign sum_s = {1'b0, b_sg_q} + {1'b0, b_sp_q};
  assign sum_g = {1'b0, b_gs_q} + {1'b0, b_gp_q};
  assign sum_p = {1'b0, b_pg_q} + {1'b0, b_ps_q};

  cmd_e               c_cmd_q;
  logic [RodIdxW-1:0] c_idx_q;
  logic [15:0]        c_roll_q;
  logic [31:0]        c_ld_len_q;
  state_e             c_ld_st_q;
  logic [27:0]        c_dg_q, c_ds_q;
  exit_calc_t         c_calc_q [3];

  always_ff @(posedge clk_i) begin
    if (mv_b) begin
      c_cmd_q        <= b_cmd_q;
      c_idx_q        <= b_idx_q;
      c_roll_q       <= b_roll_q;
      c_ld_len_q     <= b_ld_len_q;
      c_ld_st_q      <= b_ld_st_q;
      c_dg_q         <= b_dg_q;
      c_ds_q         <= b_ds_q;
      c_calc_q[0].p1  <= b_sg_q;
      c_calc_q[0].sum <= sum_s;
      c_calc_q[0].rs  <= 49'(b_roll_q) * 49'(sum_s);
      c_calc_q[1].p1  <= b_gs_q;
      c_calc_q[1].sum <= sum_g;
      c_calc_q[1].rs  <= 49'(b_roll_q) * 49'(sum_g);
      c_calc_q[2].p1  <= b_pg_q;
      c_calc_q[2].sum <= sum_p;
      c_calc_q[2].rs  <= 49'(b_roll_q) * 49'(sum_p);
    end
  end

  // candidate next state for each possible old state
  state_e cand_s, cand_g, cand_p;

  fdis_exit_pick u_pick_shrink (
    .calc_i   (c_calc_q[0]),
    .roll_i   (c_roll_q),
    .first_i  (ST_GROW),
    .second_i (ST_PAUSE),
    .stay_i   (ST_SHRINK),
    .next_o   (cand_s)
  );

  fdis_exit_pick u_pick_grow (
    .calc_i   (c_calc_q[1]),
    .roll_i   (c_roll_q),
    .first_i  (ST_SHRINK),
    .second_i (ST_PAUSE),
    .stay_i   (ST_GROW),
    .next_o   (cand_g)
  );

  fdis_exit_pick u_pick_pause (
    .calc_i   (c_calc_q[2]),
    .roll_i   (c_roll_q),
    .first_i  (ST_GROW),
    .second_i (ST_SHRINK),
    .stay_i   (ST_PAUSE),
    .next_o   (cand_p)
  );

  // --------------------------------------------------------------------------
  // Stage D: table read data, update and write-back
  // --------------------------------------------------------------------------
  cmd_e               d_cmd_q;
  logic [RodIdxW-1:0] d_idx_q;
  logic [31:0]        d_ld_len_q;
  state_e             d_ld_st_q;
  logic [27:0]        d_dg_q, d_ds_q;
  state_e             d_cand_s_q, d_cand_g_q, d_cand_p_q;

  always_ff @(posedge clk_i) begin
    if (mv_c) begin
      d_cmd_q    <= c_cmd_q;
      d_idx_q    <= c_idx_q;
      d_ld_len_q <= c_ld_len_q;
      d_ld_st_q  <= c_ld_st_q;
      d_dg_q     <= c_dg_q;
      d_ds_q     <= c_ds_q;
      d_cand_s_q <= cand_s;
      d_cand_g_q <= cand_g;
      d_cand_p_q <= cand_p;
    end
  end

  entry_t         table_mem [NUM_FILAMENTS];
  entry_t         rd_q, fwd_entry_q, wr_entry, old_entry;
  logic           fwd_q;
  logic [IdxW-1:0] c_addr, d_addr;
  state_e         pick_st, step_st;
  logic [32:0]    grow_sum;
  logic           d_changed;

  assign c_addr = IdxW'(c_idx_q);
  assign d_addr = IdxW'(d_idx_q);

  always_ff @(posedge clk_i) begin
    if (mv_d) table_mem[d_addr] <= wr_entry;
    if (mv_c) rd_q <= table_mem[c_addr];
  end

  // read and write of one entry at the same edge: bypass the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (mv_c) begin
      fwd_q <= mv_d && (d_idx_q == c_idx_q);
    end else if (mv_d) begin
      fwd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv_c) fwd_entry_q <= wr_entry;
  end

  assign old_entry = fwd_q ? fwd_entry_q : rd_q;
  assign grow_sum  = {1'b0, old_entry.len} + 33'(d_dg_q);

  always_comb begin
    unique case (old_entry.st)
      ST_SHRINK: pick_st = d_cand_s_q;
      ST_GROW:   pick_st = d_cand_g_q;
      default:   pick_st = d_cand_p_q;
    endcase

    priority if (old_entry.len > max_len_q) begin
      step_st = ST_SHRINK;
    end else if (old_entry.len <= min_len_q) begin
      step_st = ST_GROW;
    end else begin
      step_st = pick_st;
    end

    wr_entry.st = step_st;
    unique case (step_st)
      ST_GROW:   wr_entry.len = grow_sum[32] ? '1 : grow_sum[31:0];
      ST_SHRINK: wr_entry.len = ({4'h0, d_ds_q} >= old_entry.len) ? '0
                                : old_entry.len - {4'h0, d_ds_q};
      default:   wr_entry.len = old_entry.len;
    endcase
    d_changed = (step_st != old_entry.st);

    if (d_cmd_q == CMD_LOAD) begin
      wr_entry.st  = d_ld_st_q;
      wr_entry.len = d_ld_len_q;
      d_changed    = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [RodIdxW-1:0] o_idx_q;
  state_e             o_st_q;
  logic [31:0]        o_len_q;
  logic               o_chg_q;

  always_ff @(posedge clk_i) begin
    if (mv_d) begin
      o_idx_q <= d_idx_q;
      o_st_q  <= wr_entry.st;
      o_len_q <= wr_entry.len;
      o_chg_q <= d_changed;
    end
  end

  assign out_valid_o     = o_vld_q;
  assign out_index_o     = o_idx_q;
  assign new_state_o     = o_st_q;
  assign new_length_o    = o_len_q;
  assign state_changed_o = o_chg_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> d_vld_q)
    else $error("bypass flag set with no item in update stage");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled although output register is empty");

  a_load_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_d && d_cmd_q == CMD_LOAD) |=> (out_valid_o && !state_changed_o))
    else $error("load beat reported a state change");

  a_over_max_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_d && d_cmd_q == CMD_STEP && old_entry.len > max_len_q)
      |=> (new_state_o == ST_SHRINK))
    else $error("filament above max length not forced to shrink");

endmodule
`default_nettype wire

/* tb/sv/fdis_step_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdis_step_checker
// Watches the configuration port and both beat channels of the filament step
// block. Keeps its own copy of the registers and of the filament table,
// predicts the result of every accepted input beat and compares it, field by
// field, with the next result beat.
// ----------------------------------------------------------------------------
module fdis_step_checker
  import fdis_pkg::*;
#(
  parameter int unsigned NUM_FILAMENTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 command_i,
  input  logic [RodIdxW-1:0]   rod_index_i,
  input  logic [15:0]          roll_i,
  input  logic                 stabilized_i,
  input  logic [15:0]          factor_rescue_i,
  input  logic [15:0]          factor_catastrophe_i,
  input  logic [15:0]          factor_grow_speed_i,
  input  logic [15:0]          factor_shrink_speed_i,
  input  logic [31:0]          load_length_i,
  input  logic [1:0]           load_state_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [RodIdxW-1:0]   out_index_i,
  input  logic [1:0]           new_state_i,
  input  logic [31:0]          new_length_i,
  input  logic                 state_changed_i,

  output int unsigned          fail_count_o,
  output int unsigned          in_flight_o
);

  typedef struct {
    logic [RodIdxW-1:0] rod;
    state_e             st;
    logic [31:0]        len;
    logic               changed;
  } rod_update_t;

  logic [31:0] shrink_exit_q, grow_exit_q, pause_exit_q;
  logic [23:0] grow_step_q, shrink_step_q;
  logic [31:0] max_len_q, min_len_q;

  state_e      rod_st  [NUM_FILAMENTS];
  logic [31:0] rod_len [NUM_FILAMENTS];

  rod_update_t pending_updates_q [$];

  // p1, p2 are Q8.24; roll is Q0.16
  function automatic state_e exit_by_roll(input logic [15:0] roll,
                                          input logic [31:0] p1, input logic [31:0] p2,
                                          input state_e first, input state_e second,
                                          input state_e stay);
    logic [32:0] sum;
    logic [63:0] lhs, rhs;
    logic [23:0] r24;
    sum = {1'b0, p1} + {1'b0, p2};
    if (sum > OneQ24) begin
      // normalised pick: roll * sum against p1 scaled to the roll's fraction
      lhs = 64'(roll) * 64'(sum);
      rhs = {16'h0000, p1, 16'h0000};
      return (lhs < rhs) ? first : second;
    end
    r24 = {roll, 8'h00};
    if ({8'h00, r24} < p1) return first;
    if ({9'h000, r24} < sum) return second;
    return stay;
  endfunction

  function automatic rod_update_t advance_filament(
    input cmd_e cmd, input logic [RodIdxW-1:0] rod_in, input logic [15:0] roll,
    input logic stab, input logic [15:0] f_rescue, input logic [15:0] f_catas,
    input logic [15:0] f_grow, input logic [15:0] f_shrink,
    input logic [31:0] ld_len, input logic [1:0] ld_st);
    rod_update_t upd;
    logic [RodIdxW-1:0] rod;
    state_e      old_st, nxt;
    logic [31:0] len, p1, p2;
    logic [15:0] k_rescue, k_catas;
    logic [39:0] d;
    logic [40:0] grown;
    rod = RodIdxW'(rod_in % NUM_FILAMENTS);
    upd.rod = rod;
    if (cmd == CMD_LOAD) begin
      nxt = (ld_st > ST_PAUSE) ? ST_PAUSE : state_e'(ld_st);
      rod_st[rod]  = nxt;
      rod_len[rod] = ld_len;
      upd.st      = nxt;
      upd.len     = ld_len;
      upd.changed = 1'b0;
      return upd;
    end
    old_st   = rod_st[rod];
    len      = rod_len[rod];
    k_rescue = stab ? f_rescue : OneQ12;
    k_catas  = stab ? f_catas  : OneQ12;
    case (old_st)
      ST_GROW: begin
        p1  = 32'(grow_exit_q[31:16]) * 32'(k_catas);
        p2  = 32'(grow_exit_q[15:0])  * 32'(k_catas);
        nxt = exit_by_roll(roll, p1, p2, ST_SHRINK, ST_PAUSE, ST_GROW);
      end
      ST_PAUSE: begin
        p1  = 32'(pause_exit_q[31:16]) * 32'(k_rescue);
        p2  = 32'(pause_exit_q[15:0])  * 32'(k_catas);
        nxt = exit_by_roll(roll, p1, p2, ST_GROW, ST_SHRINK, ST_PAUSE);
      end
      default: begin
        p1  = 32'(shrink_exit_q[31:16]) * 32'(k_rescue);
        p2  = 32'(shrink_exit_q[15:0])  * 32'(k_rescue);
        nxt = exit_by_roll(roll, p1, p2, ST_GROW, ST_PAUSE, ST_SHRINK);
      end
    endcase
    // length bounds win over the roll
    if (len > max_len_q) nxt = ST_SHRINK;
    else if (len <= min_len_q) nxt = ST_GROW;
    if (nxt == ST_GROW) begin
      d     = stab ? ((40'(grow_step_q) * 40'(f_grow)) >> 12) : 40'(grow_step_q);
      grown = 41'(len) + 41'(d);
      len   = (grown > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    end else if (nxt == ST_SHRINK) begin
      d   = stab ? ((40'(shrink_step_q) * 40'(f_shrink)) >> 12) : 40'(shrink_step_q);
      len = (d >= 40'(len)) ? 32'h0 : len - d[31:0];
    end
    rod_st[rod]  = nxt;
    rod_len[rod] = len;
    upd.st      = nxt;
    upd.len     = len;
    upd.changed = (nxt != old_st);
    return upd;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rod_update_t want;
    if (!rst_ni) begin
      shrink_exit_q = '0;
      grow_exit_q   = '0;
      pause_exit_q  = '0;
      grow_step_q   = '0;
      shrink_step_q = '0;
      max_len_q     = 32'hFFFF_FFFF;
      min_len_q     = '0;
      pending_updates_q.delete();
      fail_count_o  = 0;
      in_flight_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SHRINK_EXIT: shrink_exit_q = cfg_wdata_i;
          REG_GROW_EXIT:   grow_exit_q   = cfg_wdata_i;
          REG_PAUSE_EXIT:  pause_exit_q  = cfg_wdata_i;
          REG_GROW_STEP:   grow_step_q   = cfg_wdata_i[23:0];
          REG_SHRINK_STEP: shrink_step_q = cfg_wdata_i[23:0];
          REG_MAX_LENGTH:  max_len_q     = cfg_wdata_i;
          REG_MIN_LENGTH:  min_len_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_updates_q.push_back(advance_filament(
          cmd_e'(command_i), rod_index_i, roll_i, stabilized_i, factor_rescue_i,
          factor_catastrophe_i, factor_grow_speed_i, factor_shrink_speed_i,
          load_length_i, load_state_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_updates_q.size() == 0) begin
          $error("result beat for rod %0d with nothing outstanding", out_index_i);
          fail_count_o++;
        end else begin
          want = pending_updates_q.pop_front();
          check_field("out_index", 32'(want.rod), 32'(out_index_i));
          check_field("new_state", 32'(want.st), 32'(new_state_i));
          check_field("new_length", want.len, new_length_i);
          check_field("state_changed", 32'(want.changed), 32'(state_changed_i));
        end
      end
      in_flight_o = pending_updates_q.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads and steps filaments in the step block under several register
// settings: a directed run over bounds, saturation and exit picks, then
// random load/step traffic with sender and receiver gaps and one long
// receiver hold. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench
  import fdis_pkg::*;
();

  localparam int unsigned NumRods       = 1024;
  localparam int unsigned HotRods       = 7;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned TailCycles    = 16;

  typedef struct packed {
    cmd_e               cmd;
    logic [RodIdxW-1:0] rod;
    logic [15:0]        roll;
    logic               stab;
    logic [15:0]        f_rescue;
    logic [15:0]        f_catas;
    logic [15:0]        f_grow;
    logic [15:0]        f_shrink;
    logic [31:0]        ld_len;
    logic [1:0]         ld_state;
  } rod_beat_t;

  localparam int unsigned BeatW = $bits(rod_beat_t);

  logic               clk_i                 = 1'b0;
  logic               rst_ni                = 1'b0;
  logic               cfg_we_i              = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i           = '0;
  logic [CfgW-1:0]    cfg_wdata_i           = '0;
  logic               in_valid_i            = 1'b0;
  logic               command_i             = 1'b0;
  logic [RodIdxW-1:0] rod_index_i           = '0;
  logic [15:0]        roll_i                = '0;
  logic               stabilized_i          = 1'b0;
  logic [15:0]        factor_rescue_i       = '0;
  logic [15:0]        factor_catastrophe_i  = '0;
  logic [15:0]        factor_grow_speed_i   = '0;
  logic [15:0]        factor_shrink_speed_i = '0;
  logic [31:0]        load_length_i         = '0;
  logic [1:0]         load_state_i          = '0;
  logic               out_ready_i           = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [RodIdxW-1:0] out_index_o;
  logic [1:0]         new_state_o;
  logic [31:0]        new_length_o;
  logic               state_changed_o;

  int unsigned        fail_count;
  int unsigned        in_flight;

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  bit                 squeeze       = 1'b0;
  bit                 squeezed      = 1'b0;
  int unsigned        stall_cycles  = 0;
  logic [31:0]        cur_max, cur_min;
  bit                 rod_loaded [NumRods];
  logic [RodIdxW-1:0] loaded_rods [$];

  filament_dynamic_instability_step #(
    .NUM_FILAMENTS (NumRods)
  ) DUT (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .rod_index_i, .roll_i, .stabilized_i,
    .factor_rescue_i, .factor_catastrophe_i, .factor_grow_speed_i,
    .factor_shrink_speed_i, .load_length_i, .load_state_i,
    .out_valid_o, .out_ready_i, .out_index_o, .new_state_o, .new_length_o,
    .state_changed_o
  );

  fdis_step_checker #(
    .NUM_FILAMENTS (NumRods)
  ) u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i (in_ready_o), .command_i, .rod_index_i, .roll_i,
    .stabilized_i, .factor_rescue_i, .factor_catastrophe_i, .factor_grow_speed_i,
    .factor_shrink_speed_i, .load_length_i, .load_state_i,
    .out_valid_i (out_valid_o), .out_ready_i, .out_index_i (out_index_o),
    .new_state_i (new_state_o), .new_length_i (new_length_o),
    .state_changed_i (state_changed_o),
    .fail_count_o (fail_count), .in_flight_o (in_flight)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: any accepted beat on either side clears it
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver; one long hold when asked so the block backs up into its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] pick_factor();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(8191));
      2:       return OneQ12;
      default: return {16{1'($urandom)}};
    endcase
  endfunction

  function automatic logic [15:0] pick_prob();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] shrink_exit, input logic [31:0] grow_exit,
                              input logic [31:0] pause_exit, input logic [31:0] grow_step,
                              input logic [31:0] shrink_step, input logic [31:0] max_len,
                              input logic [31:0] min_len);
    write_reg(REG_SHRINK_EXIT, shrink_exit);
    write_reg(REG_GROW_EXIT, grow_exit);
    write_reg(REG_PAUSE_EXIT, pause_exit);
    write_reg(REG_GROW_STEP, grow_step);
    write_reg(REG_SHRINK_STEP, shrink_step);
    write_reg(REG_MAX_LENGTH, max_len);
    write_reg(REG_MIN_LENGTH, min_len);
    cur_max = max_len;
    cur_min = min_len;
  endtask

  // Returns at the edge that accepts the beat; valid is only dropped for a gap
  task automatic send_beat(input rod_beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i            <= 1'b1;
    command_i             <= b.cmd;
    rod_index_i           <= b.rod;
    roll_i                <= b.roll;
    stabilized_i          <= b.stab;
    factor_rescue_i       <= b.f_rescue;
    factor_catastrophe_i  <= b.f_catas;
    factor_grow_speed_i   <= b.f_grow;
    factor_shrink_speed_i <= b.f_shrink;
    load_length_i         <= b.ld_len;
    load_state_i          <= b.ld_state;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_rod(input logic [RodIdxW-1:0] rod, input logic [1:0] st,
                          input logic [31:0] len);
    rod_beat_t b;
    b          = BeatW'({$urandom, $urandom, $urandom, $urandom});
    b.cmd      = CMD_LOAD;
    b.rod      = rod;
    b.ld_state = st;
    b.ld_len   = len;
    send_beat(b);
    if (!rod_loaded[rod]) begin
      rod_loaded[rod] = 1'b1;
      loaded_rods.push_back(rod);
    end
  endtask

  task automatic step_rod(input logic [RodIdxW-1:0] rod, input logic [15:0] roll,
                          input logic stab, input logic [15:0] f_rescue,
                          input logic [15:0] f_catas, input logic [15:0] f_grow,
                          input logic [15:0] f_shrink);
    rod_beat_t b;
    b          = BeatW'({$urandom, $urandom, $urandom, $urandom});
    b.cmd      = CMD_STEP;
    b.rod      = rod;
    b.roll     = roll;
    b.stab     = stab;
    b.f_rescue = f_rescue;
    b.f_catas  = f_catas;
    b.f_grow   = f_grow;
    b.f_shrink = f_shrink;
    send_beat(b);
  endtask

  // Steps only touch loaded rods; the hot set keeps repeats close together
  task automatic random_beat();
    logic [RodIdxW-1:0] rod;
    logic [31:0]        len;
    logic [15:0]        roll;
    if ($urandom_range(99) < 25) begin
      rod = ($urandom_range(2) == 0) ? RodIdxW'($urandom_range(HotRods - 1))
                                     : RodIdxW'($urandom);
      case ($urandom_range(5))
        0:       len = $urandom;
        1:       len = cur_min;
        2:       len = cur_max + 32'd1;
        3, 4:    len = $urandom_range(cur_max, cur_min);
        default: len = {32{1'($urandom)}};
      endcase
      load_rod(rod, 2'($urandom), len);
    end else begin
      rod = ($urandom_range(1) == 0) ? RodIdxW'($urandom_range(HotRods - 1))
                                     : loaded_rods[$urandom_range(loaded_rods.size() - 1)];
      case ($urandom_range(9))
        0:       roll = 16'h0000;
        1:       roll = 16'hFFFF;
        default: roll = 16'($urandom_range(65535, 1));
      endcase
      step_rod(rod, roll, 1'($urandom), pick_factor(), pick_factor(), pick_factor(),
               pick_factor());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 26;
    recv_idle_pct = 49;

    // Directed, part one: no length bounds, moderate exits, pause exits above 1.0
    program_regs(32'h0400_0200, 32'h0300_0100, 32'h0C00_0800, 32'h0001_0000,
                 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    load_rod(0, ST_GROW, 32'hFFFF_FFF0);
    step_rod(0, 16'hFFFF, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // grow saturates
    load_rod(1, ST_SHRINK, 32'h0000_8000);
    step_rod(1, 16'hFFFF, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // shrink to zero
    step_rod(1, 16'hFFFF, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // at min: forced grow
    load_rod(RodIdxW'(NumRods - 1), 2'b11, 32'h0005_0000);        // state 3 lands as pause
    step_rod(RodIdxW'(NumRods - 1), 16'h0000, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);
    load_rod(2, ST_PAUSE, 32'h0005_0000);
    step_rod(2, 16'hFFFF, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // pause second exit
    load_rod(3, ST_PAUSE, 32'h0005_0000);
    step_rod(3, 16'h8000, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);      // zero factors: stays
    step_rod(0, 16'h0001, 1'b1, OneQ12, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    step_rod(2, 16'h4000, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    step_rod(1, 16'h0000, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);
    drain();

    // Directed, part two: tight bounds, widest steps, exits at their top
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h0020_0000, 32'h0010_0000);
    load_rod(4, ST_GROW, 32'h0020_0001);
    step_rod(4, 16'h1234, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // above max
    load_rod(5, ST_SHRINK, 32'h0010_0000);
    step_rod(5, 16'hFFFF, 1'b0, OneQ12, OneQ12, OneQ12, OneQ12);  // at min
    load_rod(6, ST_PAUSE, 32'h0018_0000);
    step_rod(6, 16'h7FFF, 1'b1, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF);
    step_rod(6, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 49;
        recv_idle_pct = 26;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      squeeze = (phase == 4);
      case (phase)
        1: program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        3: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: program_regs({pick_prob(), pick_prob()}, {pick_prob(), pick_prob()},
                              {pick_prob(), pick_prob()},
                              ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000),
                              ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000),
                              $urandom_range(32'h0400_0000, 32'h0010_0000),
                              $urandom_range(32'h0008_0000));
      endcase
      repeat (ItemsPerPhase) random_beat();
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filament_dynamic_instability_step.f */
hw/rtl/fdis_pkg.sv
hw/rtl/fdis_exit_pick.sv
hw/rtl/filament_dynamic_instability_step.sv
tb/sv/fdis_step_checker.sv
tb/sv/testbench.sv
